// ----- rtl/chacha20_stream_cipher_top_macros.svh -----
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef CHACHA20_STREAM_CIPHER_TOP_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_TOP_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset
`define CC20_ASSERT_AT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block clock and reset
`define CC20_ASSERT(lbl, prop, msg) \
	`CC20_ASSERT_AT(lbl, clk, arst_n, prop, msg)

`endif

// ----- rtl/cc20_pkg.sv -----
// ----------------------------------------------------------------------------
// ChaCha20 package
// Constants, types and round helpers shared by controller and datapath.
// ----------------------------------------------------------------------------
package cc20_pkg;

	localparam int DOUBLE_ROUNDS = 10;
	// one half quarter-round step per cycle: four steps per double round
	localparam int STEPS  = 4 * DOUBLE_ROUNDS;
	localparam int STEP_W = $clog2(STEPS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

	localparam int CFG_W = 64;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_KEY0   = 3'd0;
	localparam logic [IDX_W-1:0] REG_KEY1   = 3'd1;
	localparam logic [IDX_W-1:0] REG_KEY2   = 3'd2;
	localparam logic [IDX_W-1:0] REG_KEY3   = 3'd3;
	localparam logic [IDX_W-1:0] REG_NONCE0 = 3'd4;
	localparam logic [IDX_W-1:0] REG_NONCE1 = 3'd5;
	localparam logic [IDX_W-1:0] REG_CTR    = 3'd6;

	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;

	typedef logic [31:0] word_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} qr_t;

	typedef struct packed {
		logic load_item;
		logic consume;
		logic gen_start;
		logic gen_step;
		logic gen_ff;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic ks_valid;
		logic item_end;
		logic gen_last;
	} sts_t;

	function automatic word_t rotl(input word_t v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	// first or second half of a quarter round
	function automatic qr_t qr_half(input word_t a, input word_t b, input word_t c,
			input word_t d, input logic second);
		qr_t r;
		r.a = a + b;
		r.d = second ? rotl(d ^ r.a, 8) : rotl(d ^ r.a, 16);
		r.c = c + r.d;
		r.b = second ? rotl(b ^ r.c, 7) : rotl(b ^ r.c, 12);
		return r;
	endfunction

endpackage

// ----- rtl/cc20_ctrl.sv -----
// ----------------------------------------------------------------------------
// ChaCha20 controller
// Sequences word intake, block generation, consumption and result hand-off.
// ----------------------------------------------------------------------------
module cc20_ctrl
	import cc20_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RUN  = 5'b00010,
		ST_GEN  = 5'b00100,
		ST_FF   = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					state_nxt     = ST_RUN;
				end
			end
			ST_RUN: begin
				if (!sts.ks_valid) begin
					cmd.gen_start = 1'b1;
					state_nxt     = ST_GEN;
				end else begin
					cmd.consume = 1'b1;
					if (sts.item_end) begin
						if (out_free) begin
							cmd.out_load = 1'b1;
							state_nxt    = ST_IDLE;
						end else begin
							state_nxt = ST_DONE;
						end
					end
				end
			end
			ST_GEN: begin
				cmd.gen_step = 1'b1;
				if (sts.gen_last) begin
					state_nxt = ST_FF;
				end
			end
			ST_FF: begin
				cmd.gen_ff = 1'b1;
				state_nxt  = ST_RUN;
			end
			ST_DONE: begin
				// hold the finished word until the output register frees
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/cc20_datapath.sv -----
// ----------------------------------------------------------------------------
// ChaCha20 datapath
// Configuration registers, iterated round unit, keystream shift register,
// word assembly and output register.
// ----------------------------------------------------------------------------
module cc20_datapath
	import cc20_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic [31:0]      in_data,
	input  logic [2:0]       in_count,
	input  logic             in_last,
	input  cmd_t             cmd,
	output sts_t             sts,
	output logic [31:0]      out_data,
	output logic [2:0]       out_bytes,
	output logic [31:0]      out_counter,
	output logic             out_last
);

	logic [CFG_W-1:0]  key_q [4];
	logic [CFG_W-1:0]  nonce0_q;
	logic [31:0]       nonce1_q;
	logic [31:0]       counter_q;
	logic              valid_q;
	logic [5:0]        pos_q;
	logic [511:0]      ks_q;
	word_t             w_q   [16];
	word_t             w_nxt [16];
	word_t             init  [16];
	logic [STEP_W-1:0] step_q;

	logic [31:0] data_q;
	logic [2:0]  n_q;
	logic [2:0]  k_q;
	logic        last_q;
	logic [31:0] res_q;

	logic        cfg_hit;
	logic [2:0]  n_dec;
	logic [6:0]  avail;
	logic [2:0]  rem;
	logic [2:0]  m;
	logic [2:0]  k_sum;
	logic [6:0]  pos_sum;
	logic [31:0] res_nxt;
	logic [511:0] ks_shift;

	logic [3:0] ia [4];
	logic [3:0] ib [4];
	logic [3:0] ic [4];
	logic [3:0] id [4];
	qr_t        qr [4];

	assign cfg_hit = cfg_we && (cfg_addr <= REG_CTR);
	assign n_dec   = (in_count == 3'd0 || in_count > 3'd4) ? 3'd4 : in_count;

	// initial block state
	always_comb begin
		init[0] = SIGMA0;
		init[1] = SIGMA1;
		init[2] = SIGMA2;
		init[3] = SIGMA3;
		for (int i = 0; i < 4; i++) begin
			init[4 + 2 * i] = key_q[i][31:0];
			init[5 + 2 * i] = key_q[i][63:32];
		end
		init[12] = counter_q;
		init[13] = nonce0_q[31:0];
		init[14] = nonce0_q[63:32];
		init[15] = nonce1_q;
	end

	// four quarter rounds in parallel, column or diagonal by step bit 1
	always_comb begin
		for (int g = 0; g < 4; g++) begin
			ia[g] = {2'b00, 2'(g)};
			ib[g] = {2'b01, 2'(g) + {1'b0, step_q[1]}};
			ic[g] = {2'b10, 2'(g) + {step_q[1], 1'b0}};
			id[g] = {2'b11, 2'(g) - {1'b0, step_q[1]}};
			qr[g] = qr_half(w_q[ia[g]], w_q[ib[g]], w_q[ic[g]], w_q[id[g]], step_q[0]);
		end
	end

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			w_nxt[i] = w_q[i];
		end
		for (int g = 0; g < 4; g++) begin
			w_nxt[ia[g]] = qr[g].a;
			w_nxt[ib[g]] = qr[g].b;
			w_nxt[ic[g]] = qr[g].c;
			w_nxt[id[g]] = qr[g].d;
		end
	end

	// bytes taken this cycle: what the word still needs, capped by the block
	assign avail   = 7'd64 - {1'b0, pos_q};
	assign rem     = n_q - k_q;
	assign m       = !valid_q ? 3'd0 : ((avail < {4'b0000, rem}) ? avail[2:0] : rem);
	assign k_sum   = k_q + m;
	assign pos_sum = {1'b0, pos_q} + {4'b0000, m};

	always_comb begin
		res_nxt = res_q;
		for (int i = 0; i < 4; i++) begin
			if ((3'(i) >= k_q) && (4'(i) < ({1'b0, k_q} + {1'b0, m}))) begin
				res_nxt[8 * i +: 8] = data_q[8 * i +: 8]
					^ ks_q[{2'(i) - k_q[1:0], 3'b000} +: 8];
			end
		end
	end

	always_comb begin
		case (m)
			3'd1:    ks_shift = ks_q >> 8;
			3'd2:    ks_shift = ks_q >> 16;
			3'd3:    ks_shift = ks_q >> 24;
			3'd4:    ks_shift = ks_q >> 32;
			default: ks_shift = ks_q;
		endcase
	end

	assign sts.ks_valid = valid_q;
	assign sts.item_end = valid_q && (k_sum == n_q);
	assign sts.gen_last = (step_q == STEP_LAST);

	// configuration, counter and keystream position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= '0;
			end
			nonce0_q  <= '0;
			nonce1_q  <= '0;
			counter_q <= '0;
			valid_q   <= 1'b0;
			pos_q     <= '0;
			step_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_KEY0:   key_q[0]  <= cfg_data;
					REG_KEY1:   key_q[1]  <= cfg_data;
					REG_KEY2:   key_q[2]  <= cfg_data;
					REG_KEY3:   key_q[3]  <= cfg_data;
					REG_NONCE0: nonce0_q  <= cfg_data;
					REG_NONCE1: nonce1_q  <= cfg_data[31:0];
					REG_CTR:    counter_q <= cfg_data[31:0];
					default: ;
				endcase
			end else if (cmd.gen_ff) begin
				counter_q <= counter_q + 32'd1;
			end

			if (cfg_hit) begin
				valid_q <= 1'b0;
				pos_q   <= '0;
			end else if (cmd.gen_ff) begin
				valid_q <= 1'b1;
				pos_q   <= '0;
			end else if (cmd.consume) begin
				// drop the rest of the block at end of call or when used up
				if ((sts.item_end && last_q) || pos_sum[6]) begin
					valid_q <= 1'b0;
					pos_q   <= '0;
				end else begin
					pos_q <= pos_sum[5:0];
				end
			end

			if (cmd.gen_start) begin
				step_q <= '0;
			end else if (cmd.gen_step) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	// round state and keystream
	always_ff @(posedge clk) begin
		if (cmd.gen_start) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= init[i];
			end
		end else if (cmd.gen_step) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= w_nxt[i];
			end
		end

		if (cmd.gen_ff) begin
			for (int i = 0; i < 16; i++) begin
				ks_q[32 * i +: 32] <= w_q[i] + init[i];
			end
		end else if (cmd.consume) begin
			ks_q <= ks_shift;
		end
	end

	// word in flight and output register
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			data_q <= in_data;
			n_q    <= n_dec;
			k_q    <= '0;
			last_q <= in_last;
			res_q  <= '0;
		end else if (cmd.consume) begin
			res_q <= res_nxt;
			k_q   <= k_sum;
		end

		if (cmd.out_load) begin
			out_data    <= cmd.consume ? res_nxt : res_q;
			out_bytes   <= n_q;
			out_counter <= counter_q;
			out_last    <= last_q;
		end
	end

endmodule

// ----- rtl/chacha20_stream_cipher_top.sv -----
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher top level
// Encrypts or decrypts a stream of 1 to 4 byte words with a ChaCha20
// keystream built from the configured key, nonce and block counter.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tdata: data_in, byte_count; tlast
//  m_       | out       | m_tvalid/m_tready  | m_tdata: data_out, bytes_out,
//           |           |                    |   next_block_counter; tlast
//  cfg_     | in        | cfg_we             | cfg_addr, cfg_data
//
// A word served from the held block is accepted, then combined.
// A word that needs a new block waits for it: the shared round unit loads the
// initial state, does one half quarter-round step per cycle and then adds the
// feed-forward. A word straddling two blocks pays this wait only
// once. Reset clears control state and configuration; no clearing pass.
// A stalled output holds one result while the next word is taken in.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_top
	import cc20_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [39:0]      s_tdata,  // [31:0] data_in, [34:32] byte_count, rest zero
	input  logic             s_tlast,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [71:0]      m_tdata,  // [31:0] data_out, [34:32] bytes_out,
	                                   // [66:35] next_block_counter, rest zero
	output logic             m_tlast,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0] cfg_data
);

	cmd_t        cmd;
	sts_t        sts;
	logic [31:0] out_data;
	logic [2:0]  out_bytes;
	logic [31:0] out_counter;

	cc20_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cc20_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_data    (cfg_data),
		.in_data     (s_tdata[31:0]),
		.in_count    (s_tdata[34:32]),
		.in_last     (s_tlast),
		.cmd         (cmd),
		.sts         (sts),
		.out_data    (out_data),
		.out_bytes   (out_bytes),
		.out_counter (out_counter),
		.out_last    (m_tlast)
	);

	assign m_tdata = {5'b00000, out_counter, out_bytes, out_data};

endmodule

// ----- rtl/cc20_checker.sv -----
// ----------------------------------------------------------------------------
// ChaCha20 port checker
// Watches the top level ports for stream and result consistency.
// ----------------------------------------------------------------------------
`include "chacha20_stream_cipher_top_macros.svh"

module cc20_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);

	// a stalled result stays offered
	`CC20_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

	// one word at a time: intake closes right after an accept
	`CC20_ASSERT(a_one_word, s_tvalid && s_tready |=> !s_tready, "word accepted while busy")

	`CC20_ASSERT(a_bytes_range, m_tvalid |-> (m_tdata[34:32] != 3'd0 && m_tdata[34:32] <= 3'd4), "bytes_out out of range")

	// bytes beyond a one-byte count read as zero
	`CC20_ASSERT(a_pad_zero, m_tvalid && m_tdata[34:32] == 3'd1 |-> m_tdata[31:8] == 24'd0, "padding not zero")

endmodule

bind chacha20_stream_cipher_top cc20_checker u_cc20_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher testbench
// Drives plaintext words through the stream port under random idling and two
// long output stalls, predicts each ciphertext word from its own ChaCha20
// keystream generator, and compares every output word field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import cc20_pkg::*;

	// beyond the register list: the block must ignore it
	localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

	typedef struct {
		logic [31:0] data;
		logic [2:0]  nbytes;
		logic [31:0] next_ctr;
		logic        last;
	} cipher_word_t;

	class cipher_scoreboard;
		logic [63:0] key [4];
		logic [63:0] nonce_lo;
		logic [31:0] nonce_hi;
		logic [31:0] counter;
		logic [31:0] ks [16];
		logic [31:0] mix [16];
		int          pos;
		bit          have_block;
		cipher_word_t expected_words [$];
		int          faults;

		function new();
			foreach (key[i]) key[i] = '0;
			nonce_lo   = '0;
			nonce_hi   = '0;
			counter    = '0;
			pos        = 0;
			have_block = 0;
			faults     = 0;
		endfunction

		function logic [31:0] rol(logic [31:0] v, int n);
			return (v << n) | (v >> (32 - n));
		endfunction

		function void quarter(int a, int b, int c, int d);
			mix[a] += mix[b]; mix[d] = rol(mix[d] ^ mix[a], 16);
			mix[c] += mix[d]; mix[b] = rol(mix[b] ^ mix[c], 12);
			mix[a] += mix[b]; mix[d] = rol(mix[d] ^ mix[a], 8);
			mix[c] += mix[d]; mix[b] = rol(mix[b] ^ mix[c], 7);
		endfunction

		// build the next 64-byte block from key, counter and nonce
		function void refill();
			logic [31:0] seed [16];
			seed[0] = SIGMA0;
			seed[1] = SIGMA1;
			seed[2] = SIGMA2;
			seed[3] = SIGMA3;
			for (int i = 0; i < 4; i++) begin
				seed[4 + 2 * i] = key[i][31:0];
				seed[5 + 2 * i] = key[i][63:32];
			end
			seed[12] = counter;
			seed[13] = nonce_lo[31:0];
			seed[14] = nonce_lo[63:32];
			seed[15] = nonce_hi;
			foreach (seed[i]) mix[i] = seed[i];
			for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
				quarter(0, 4, 8, 12);
				quarter(1, 5, 9, 13);
				quarter(2, 6, 10, 14);
				quarter(3, 7, 11, 15);
				quarter(0, 5, 10, 15);
				quarter(1, 6, 11, 12);
				quarter(2, 7, 8, 13);
				quarter(3, 4, 9, 14);
			end
			foreach (ks[i]) ks[i] = mix[i] + seed[i];
			counter    = counter + 32'd1;
			pos        = 0;
			have_block = 1;
		endfunction

		function logic [7:0] take_key_byte();
			logic [7:0] b;
			if (!have_block)
				refill();
			b = ks[pos / 4] >> ((pos % 4) * 8);
			pos++;
			if (pos >= 64) begin
				pos        = 0;
				have_block = 0;
			end
			return b;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [63:0] val);
			case (idx)
				REG_KEY0:   key[0]   = val;
				REG_KEY1:   key[1]   = val;
				REG_KEY2:   key[2]   = val;
				REG_KEY3:   key[3]   = val;
				REG_NONCE0: nonce_lo = val;
				REG_NONCE1: nonce_hi = val[31:0];
				REG_CTR:    counter  = val[31:0];
				default:    return;
			endcase
			have_block = 0;
			pos        = 0;
		endfunction

		function void note_plain_word(logic [31:0] data, logic [2:0] nbytes, logic last);
			cipher_word_t w;
			int n;
			n = (nbytes == 3'd0 || nbytes > 3'd4) ? 4 : int'(nbytes);
			w.data = '0;
			for (int i = 0; i < n; i++)
				w.data[8 * i +: 8] = data[8 * i +: 8] ^ take_key_byte();
			// end of message: drop the rest of the block
			if (last) begin
				have_block = 0;
				pos        = 0;
			end
			w.nbytes   = 3'(n);
			w.next_ctr = counter;
			w.last     = last;
			expected_words.push_back(w);
		endfunction

		function void check_cipher_word(logic [71:0] tdata, logic tlast);
			cipher_word_t w;
			if (expected_words.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected output word: data %h bytes %0d ctr %h last %b",
						tdata[31:0], tdata[34:32], tdata[66:35], tlast);
				return;
			end
			w = expected_words.pop_front();
			if (tdata[31:0] !== w.data || tdata[34:32] !== w.nbytes ||
					tdata[66:35] !== w.next_ctr || tlast !== w.last) begin
				faults++;
				if (faults <= 10)
					$display("word mismatch: exp data %h bytes %0d ctr %h last %b, got data %h bytes %0d ctr %h last %b",
						w.data, w.nbytes, w.next_ctr, w.last,
						tdata[31:0], tdata[34:32], tdata[66:35], tlast);
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [39:0]      s_tdata = '0;
	logic             s_tlast = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [71:0]      m_tdata;
	logic             m_tlast;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	logic calm = 1'b0;
	int   words_out = 0;
	int   hold_left = 0;

	cipher_scoreboard sb = new();

	chacha20_stream_cipher_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// output side: check every accepted word, stall at random or hold off
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_cipher_word(m_tdata, m_tlast);
			words_out++;
			if (words_out == 150 || words_out == 620)
				hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (calm) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= 11);
		end
	end

	task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes,
			input logic last);
		while (!calm && $urandom_range(0, 99) < 11) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, nbytes, data};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_plain_word(data, nbytes, last);
	endtask

	// wait until every word is out and the block has gone quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic configure(input logic [7:0] sel, input logic [63:0] k0, k1, k2, k3,
			n0, input logic [31:0] n1, ctr);
		logic [63:0] vals [8];
		vals[REG_KEY0]   = k0;
		vals[REG_KEY1]   = k1;
		vals[REG_KEY2]   = k2;
		vals[REG_KEY3]   = k3;
		vals[REG_NONCE0] = n0;
		vals[REG_NONCE1] = {32'd0, n1};
		vals[REG_CTR]    = {32'd0, ctr};
		vals[REG_NONE]   = k0;
		for (int i = 0; i < 8; i++) begin
			if (sel[i]) begin
				cfg_we   <= 1'b1;
				cfg_addr <= IDX_W'(i);
				cfg_data <= vals[i];
				@(posedge clk);
				sb.write_reg(IDX_W'(i), vals[i]);
			end
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int budget;
		int len;
		int mode;
		bit closed;
		logic [2:0] nb;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset key and nonce: extremes of data, every byte count
		send_word(32'h0000_0000, 3'd4, 1'b0);
		send_word(32'hFFFF_FFFF, 3'd4, 1'b0);
		send_word($urandom, 3'd1, 1'b0);
		send_word($urandom, 3'd2, 1'b0);
		send_word($urandom, 3'd3, 1'b0);
		send_word($urandom, 3'd0, 1'b0);
		send_word($urandom, 3'd5, 1'b0);
		send_word($urandom, 3'd6, 1'b1);
		send_word($urandom, 3'd7, 1'b0);
		send_word(32'hFFFF_FFFF, 3'd3, 1'b1);
		settle();

		// all ones, counter about to wrap; write the unused index too
		configure(8'hFF, '1, '1, '1, '1, '1, '1, 32'hFFFF_FFFF);
		// misalign by one byte so a word straddles two blocks
		send_word($urandom, 3'd1, 1'b0);
		repeat (16) send_word($urandom, 3'd4, 1'b0);
		settle();

		for (int p = 0; p < 8; p++) begin
			mode = (p < 5) ? p : $urandom_range(0, 4);
			case (mode)
				0: configure(8'h7F, '0, '0, '0, '0, '0, '0, '0);
				1: configure(8'h7F, '1, '1, '1, '1, '1, '1, '1);
				2: configure(8'h7F, {$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, $urandom, $urandom);
				3: configure(8'($urandom_range(0, 255)), {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom);
				default: configure(8'h40, '0, '0, '0, '0, '0, '0,
					32'hFFFF_FFFF - $urandom_range(0, 3));
			endcase
			calm <= (p == 3);
			budget = 0;
			while (budget < 92) begin
				len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 20)
					: $urandom_range(21, 48);
				// some messages stop without an end marker
				closed = ($urandom_range(0, 99) >= 15);
				for (int k = 0; k < len; k++) begin
					if (k == len - 1)
						nb = 3'($urandom_range(1, 4));
					else if ($urandom_range(0, 99) < 8)
						nb = 3'($urandom_range(0, 7));
					else
						nb = 3'd4;
					send_word($urandom, nb, closed && (k == len - 1));
				end
				budget += len;
			end
			settle();
		end

		calm <= 1'b0;
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.faults == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
